### src/plp_pkg.sv
// shared types and constants for the point-to-line projection block
// depends on nothing; used by plp_div_cell and point_line_projection
package plp_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
   localparam int MAG_WIDTH       = PROD_WIDTH + 1;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int PARAM_WIDTH     = 32;
   localparam int QUOT_BITS       = PARAM_WIDTH + 1;

   // input word
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic signed [COORD_WIDTH-1:0] query_x;
      logic signed [COORD_WIDTH-1:0] query_y;
   } point_req_type;

   // result word
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] nearest_x;
      logic signed [COORD_WIDTH-1:0] nearest_y;
      logic signed [PARAM_WIDTH-1:0] line_param;
      logic                          degenerate;
      logic                          clipped;
   } point_rsp_type;

   // per-word data carried alongside the divider
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] sx;
      logic signed [COORD_WIDTH-1:0] sy;
      logic signed [DIFF_WIDTH-1:0]  dx;
      logic signed [DIFF_WIDTH-1:0]  dy;
      logic                          degen;
      logic                          neg;
      logic                          ovf;
   } plp_side_type;

endpackage

### src/point_line_projection.sv
// top level: projects a point onto the line through two points
// depends on plp_pkg and plp_div_cell
//
// usage:
//   a word is taken on req_word at a rising edge where start is high and
//   busy is low; busy is always low, so a new word may enter every cycle.
//   each word gives exactly one result on rsp_word, marked by rsp_strobe
//   for one cycle; the differences are registered at the edge that takes
//   the word, then the products and then the dot/length sums are registered,
//   a chain of 33 divider cells produces one quotient bit each, and further
//   registers clamp t, multiply t by the direction, and shift, add and
//   clamp the point.
//   throughput is one word per cycle, set by the fully pipelined chain.
//   reset clears every valid bit of the pipeline; words in flight are lost.
//   the receiver cannot stall, so results are never held back.
//   coincident line points give the start point, t = 0 and degenerate set.
module point_line_projection #(
   parameter int PARAM_FRAC_BITS = plp_pkg::PARAM_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  plp_pkg::point_req_type req_word,
   output logic                   rsp_strobe,
   output plp_pkg::point_rsp_type rsp_word
);

   localparam int CW  = plp_pkg::COORD_WIDTH;
   localparam int DW  = plp_pkg::DIFF_WIDTH;
   localparam int PW  = plp_pkg::PROD_WIDTH;
   localparam int MW  = plp_pkg::MAG_WIDTH;
   localparam int TW  = plp_pkg::PARAM_WIDTH;
   localparam int QB  = plp_pkg::QUOT_BITS;
   localparam int NW  = MW + PARAM_FRAC_BITS;
   localparam int OW  = NW + QB;
   localparam int XW  = TW + DW;
   localparam int SW  = XW + 1;
   localparam logic [QB-1:0] NEG_LIMIT = QB'(64'd1 << (TW - 1));
   localparam logic [QB-1:0] POS_LIMIT = QB'((64'd1 << (TW - 1)) - 64'd1);
   localparam logic signed [CW-1:0] C_MAX = CW'((64'd1 << (CW - 1)) - 64'd1);
   localparam logic signed [CW-1:0] C_MIN = CW'(64'd1 << (CW - 1));
   localparam logic signed [TW-1:0] T_MAX = TW'((64'd1 << (TW - 1)) - 64'd1);
   localparam logic signed [TW-1:0] T_MIN = TW'(64'd1 << (TW - 1));

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // stage 1: differences
   logic                  v1_ff;
   plp_pkg::plp_side_type side1_ff, side1_in;
   logic signed [DW-1:0]  wx1_ff, wy1_ff, wx1_in, wy1_in;

   always_comb begin
      side1_in.sx    = req_word.start_x;
      side1_in.sy    = req_word.start_y;
      side1_in.dx    = DW'(req_word.end_x) - DW'(req_word.start_x);
      side1_in.dy    = DW'(req_word.end_y) - DW'(req_word.start_y);
      side1_in.degen = (req_word.end_x == req_word.start_x) &&
                       (req_word.end_y == req_word.start_y);
      side1_in.neg   = 1'b0;
      side1_in.ovf   = 1'b0;
      wx1_in = DW'(req_word.query_x) - DW'(req_word.start_x);
      wy1_in = DW'(req_word.query_y) - DW'(req_word.start_y);
   end

   // stage 2: products
   logic                  v2_ff;
   plp_pkg::plp_side_type side2_ff;
   logic signed [PW-1:0]  xx2_ff, yy2_ff, wxd2_ff, wyd2_ff;

   // stage 3: squared length, dot product magnitude and sign
   logic                  v3_ff;
   plp_pkg::plp_side_type side3_ff, side3_in;
   logic [MW-1:0]         len2_ff, len2_in, mag_ff, mag_in;
   logic signed [MW-1:0]  dot;

   always_comb begin
      len2_in = MW'(xx2_ff) + MW'(yy2_ff);
      dot     = MW'(wxd2_ff) + MW'(wyd2_ff);
      mag_in  = dot[MW-1] ? MW'(-dot) : MW'(dot);
      side3_in     = side2_ff;
      side3_in.neg = dot[MW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      wx1_ff   <= wx1_in;
      wy1_ff   <= wy1_in;
      side2_ff <= side1_ff;
      xx2_ff   <= side1_ff.dx * side1_ff.dx;
      yy2_ff   <= side1_ff.dy * side1_ff.dy;
      wxd2_ff  <= wx1_ff * side1_ff.dx;
      wyd2_ff  <= wy1_ff * side1_ff.dy;
      side3_ff <= side3_in;
      len2_ff  <= len2_in;
      mag_ff   <= mag_in;
   end

   // chain entry: numerator and quotient overflow check
   logic [NW-1:0]         num;
   plp_pkg::plp_side_type side_entry;

   always_comb begin
      num            = {mag_ff, PARAM_FRAC_BITS'(0)};
      side_entry     = side3_ff;
      side_entry.ovf = OW'(num) >= (OW'(len2_ff) << QB);
   end

   // divider chain, one quotient bit per cell, most significant first
   logic                  cv   [QB+1];
   logic [NW-1:0]         crem [QB+1];
   logic [MW-1:0]         clen [QB+1];
   logic [QB-1:0]         cq   [QB+1];
   plp_pkg::plp_side_type cside[QB+1];

   assign cv[0]    = v3_ff;
   assign crem[0]  = num;
   assign clen[0]  = len2_ff;
   assign cq[0]    = '0;
   assign cside[0] = side_entry;

   for (genvar g = 0; g < QB; g++) begin : g_cell
      plp_div_cell #(
         .NUM_WIDTH (NW),
         .SHIFT     (QB - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[g]),
         .in_rem    (crem[g]),
         .in_len2   (clen[g]),
         .in_quot   (cq[g]),
         .in_side   (cside[g]),
         .out_valid (cv[g+1]),
         .out_rem   (crem[g+1]),
         .out_len2  (clen[g+1]),
         .out_quot  (cq[g+1]),
         .out_side  (cside[g+1])
      );
   end

   // clamp t to the signed parameter range
   logic                  vt_ff;
   plp_pkg::plp_side_type sidet_ff;
   logic signed [TW-1:0]  t_ff, t_in;
   logic                  clipt_ff, clipt_in;
   logic [QB-1:0]         q;
   logic signed [QB:0]    negq;

   always_comb begin
      q        = cq[QB];
      negq     = -$signed({1'b0, q});
      clipt_in = 1'b0;
      if (cside[QB].degen) begin
         t_in = '0;
      end else if (cside[QB].neg) begin
         if (cside[QB].ovf || (q > NEG_LIMIT)) begin
            t_in     = T_MIN;
            clipt_in = 1'b1;
         end else begin
            t_in = negq[TW-1:0];
         end
      end else begin
         if (cside[QB].ovf || (q > POS_LIMIT)) begin
            t_in     = T_MAX;
            clipt_in = 1'b1;
         end else begin
            t_in = q[TW-1:0];
         end
      end
   end

   // t times direction
   logic                  vm_ff;
   plp_pkg::plp_side_type sidem_ff;
   logic signed [TW-1:0]  tm_ff;
   logic                  clipm_ff;
   logic signed [XW-1:0]  px_ff, py_ff;

   // floor shift, add start point, clamp
   logic signed [SW-1:0]  sumx, sumy;
   logic signed [XW-1:0]  shx, shy;
   logic                  hitx, hity;
   plp_pkg::point_rsp_type rsp_in, rsp_ff;
   logic                  rsp_valid_ff;

   always_comb begin
      shx  = px_ff >>> PARAM_FRAC_BITS;
      shy  = py_ff >>> PARAM_FRAC_BITS;
      sumx = SW'(sidem_ff.sx) + SW'(shx);
      sumy = SW'(sidem_ff.sy) + SW'(shy);
      hitx = (sumx > SW'(C_MAX)) || (sumx < SW'(C_MIN));
      hity = (sumy > SW'(C_MAX)) || (sumy < SW'(C_MIN));
      rsp_in.nearest_x  = (sumx > SW'(C_MAX)) ? C_MAX :
                          (sumx < SW'(C_MIN)) ? C_MIN : sumx[CW-1:0];
      rsp_in.nearest_y  = (sumy > SW'(C_MAX)) ? C_MAX :
                          (sumy < SW'(C_MIN)) ? C_MIN : sumy[CW-1:0];
      rsp_in.line_param = tm_ff;
      rsp_in.degenerate = sidem_ff.degen;
      rsp_in.clipped    = clipm_ff | hitx | hity;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vt_ff        <= cv[QB];
         vm_ff        <= vt_ff;
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      sidet_ff <= cside[QB];
      t_ff     <= t_in;
      clipt_ff <= clipt_in;
      sidem_ff <= sidet_ff;
      tm_ff    <= t_ff;
      clipm_ff <= clipt_ff;
      px_ff    <= t_ff * sidet_ff.dx;
      py_ff    <= t_ff * sidet_ff.dy;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

### src/plp_div_cell.sv
// one restoring division step of the projection divider chain
// depends on plp_pkg
module plp_div_cell #(
   parameter int NUM_WIDTH = plp_pkg::MAG_WIDTH + plp_pkg::PARAM_FRAC_BITS,
   parameter int SHIFT     = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [NUM_WIDTH-1:0]                 in_rem,
   input  logic [plp_pkg::MAG_WIDTH-1:0]        in_len2,
   input  logic [plp_pkg::QUOT_BITS-1:0]        in_quot,
   input  plp_pkg::plp_side_type                in_side,
   output logic                                 out_valid,
   output logic [NUM_WIDTH-1:0]                 out_rem,
   output logic [plp_pkg::MAG_WIDTH-1:0]        out_len2,
   output logic [plp_pkg::QUOT_BITS-1:0]        out_quot,
   output plp_pkg::plp_side_type                out_side
);

   localparam int TW = NUM_WIDTH + plp_pkg::QUOT_BITS;

   logic [TW-1:0]                  trial;
   logic                           fits;
   logic                           valid_ff;
   logic [NUM_WIDTH-1:0]           rem_ff, rem_in;
   logic [plp_pkg::MAG_WIDTH-1:0]  len2_ff;
   logic [plp_pkg::QUOT_BITS-1:0]  quot_ff, quot_in;
   plp_pkg::plp_side_type          side_ff;

   // compare and subtract the shifted divisor
   always_comb begin
      trial   = TW'(in_len2) << SHIFT;
      fits    = TW'(in_rem) >= trial;
      rem_in  = fits ? (in_rem - trial[NUM_WIDTH-1:0]) : in_rem;
      quot_in = {in_quot[plp_pkg::QUOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      len2_ff <= in_len2;
      quot_ff <= quot_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_len2  = len2_ff;
   assign out_quot  = quot_ff;
   assign out_side  = side_ff;

endmodule
